### hw/rtl/lcfd_pkg.sv
// lcfd_pkg: shared types and constants of the length-checked frame deframer
// used by the core, the output stage, the top level and the checker
`default_nettype none

package lcfd_pkg;

    // header hunter phase, one-hot
    typedef enum logic [3:0] {
        PH_HUNT      = 4'b0001,
        PH_SAW_FIRST = 4'b0010,
        PH_HEADER    = 4'b0100,
        PH_PAYLOAD   = 4'b1000
    } t_phase;

    // kind of a result item
    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_EMPTY     = 2'd1,
        KIND_BAD_CHECK = 2'd2,
        KIND_TOO_LONG  = 2'd3
    } t_kind;

    // configuration register indexes
    localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // reset values of the configuration registers
    localparam logic [7:0]  SYNC_FIRST_RST  = 8'hA3;
    localparam logic [7:0]  SYNC_SECOND_RST = 8'h97;
    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd297;

    // one result from the core to the output stage
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        t_kind      kind;
        logic       last;
    } t_result;

endpackage

`default_nettype wire

### hw/rtl/lcfd_core.sv
// lcfd_core: sync hunt, header check, header rescan and payload count
// depends on lcfd_pkg; feeds a result for each payload byte and header outcome to lcfd_outreg
`default_nettype none

module lcfd_core
    import lcfd_pkg::*;
#(
    parameter int LEN_WIDTH = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire logic [7:0]            i_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_result                    o_res
);

    t_phase                 r_phase, n_phase;
    logic [1:0]             r_idx, n_idx;
    logic [LEN_WIDTH-1:0]   r_left, n_left;
    logic [3:0][7:0]        r_rep, n_rep;
    logic [7:0]             r_sync1, r_sync2;
    logic [15:0]            r_max;

    logic [LEN_WIDTH-1:0]   len_w, chk_w, sum_w;
    logic [3:0][7:0]        held;
    t_phase                 s_ph;
    logic [1:0]             s_idx;
    logic [3:0][7:0]        s_rep;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync1 <= SYNC_FIRST_RST;
            r_sync2 <= SYNC_SECOND_RST;
            r_max   <= MAX_PAYLOAD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SYNC_FIRST:  r_sync1 <= i_cfg_data[7:0];
                REG_SYNC_SECOND: r_sync2 <= i_cfg_data[7:0];
                REG_MAX_PAYLOAD: r_max   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // header words as they stand once the fourth header byte arrives
    assign len_w = LEN_WIDTH'({r_rep[1], r_rep[0]});
    assign chk_w = LEN_WIDTH'({i_data, r_rep[2]});
    assign sum_w = len_w + chk_w;

    // rescan of the four header bytes after a rejected header
    always_comb begin
        held  = {i_data, r_rep[2], r_rep[1], r_rep[0]};
        s_ph  = PH_HUNT;
        s_idx = 2'd0;
        s_rep = r_rep;
        for (int k = 0; k < 4; k++) begin
            unique case (s_ph)
                PH_SAW_FIRST: begin
                    if (held[k] == r_sync2) begin
                        s_ph  = PH_HEADER;
                        s_idx = 2'd0;
                    end else if (held[k] != r_sync1) begin
                        s_ph = PH_HUNT;
                    end
                end
                PH_HEADER: begin
                    s_rep[s_idx] = held[k];
                    s_idx        = s_idx + 2'd1;
                end
                default: begin
                    s_ph = (held[k] == r_sync1) ? PH_SAW_FIRST : PH_HUNT;
                end
            endcase
        end
    end

    // next state and result for one accepted byte
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_left  = r_left;
        n_rep   = r_rep;
        o_res   = '{valid: 1'b0, data: 8'd0, kind: KIND_PAYLOAD, last: 1'b0};
        if (i_accept) begin
            unique case (r_phase)
                PH_PAYLOAD: begin
                    o_res.valid = 1'b1;
                    o_res.data  = i_data;
                    if (r_left <= LEN_WIDTH'(1)) begin
                        o_res.last = 1'b1;
                        n_left     = '0;
                        n_phase    = PH_HUNT;
                    end else begin
                        n_left = r_left - LEN_WIDTH'(1);
                    end
                end
                PH_HEADER: begin
                    if (r_idx != 2'd3) begin
                        n_rep[r_idx] = i_data;
                        n_idx        = r_idx + 2'd1;
                    end else begin
                        priority if (sum_w != '0) begin
                            o_res.valid = 1'b1;
                            o_res.kind  = KIND_BAD_CHECK;
                            n_phase     = s_ph;
                            n_idx       = s_idx;
                            n_rep       = s_rep;
                        end else if (16'(len_w) > r_max) begin
                            o_res.valid = 1'b1;
                            o_res.kind  = KIND_TOO_LONG;
                            n_phase     = s_ph;
                            n_idx       = s_idx;
                            n_rep       = s_rep;
                        end else if (len_w == '0) begin
                            o_res.valid = 1'b1;
                            o_res.kind  = KIND_EMPTY;
                            n_phase     = PH_HUNT;
                            n_idx       = 2'd0;
                        end else begin
                            n_phase = PH_PAYLOAD;
                            n_left  = len_w;
                            n_idx   = 2'd0;
                        end
                    end
                end
                PH_SAW_FIRST: begin
                    if (i_data == r_sync2) begin
                        n_phase = PH_HEADER;
                        n_idx   = 2'd0;
                    end else if (i_data != r_sync1) begin
                        n_phase = PH_HUNT;
                    end
                end
                default: begin
                    n_phase = (i_data == r_sync1) ? PH_SAW_FIRST : PH_HUNT;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_idx   <= 2'd0;
            r_left  <= '0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_left  <= n_left;
        end
    end

    // held header bytes, no reset
    always_ff @(posedge i_clk) begin
        r_rep <= n_rep;
    end

endmodule

`default_nettype wire

### hw/rtl/lcfd_outreg.sv
// lcfd_outreg: output register between the core and the result stream
// depends on lcfd_pkg for the result struct
`default_nettype none

module lcfd_outreg
    import lcfd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_result i_res,
    input  wire logic    i_ready,
    output logic         o_free,
    output logic         o_valid,
    output logic [7:0]   o_data,
    output t_kind        o_kind,
    output logic         o_last
);

    logic  r_valid, n_valid;
    logic  [7:0] r_data;
    t_kind r_kind;
    logic  r_last;

    // slot can take a new result when empty or being drained
    assign o_free  = !r_valid || i_ready;
    assign n_valid = i_res.valid ? 1'b1 : (i_ready ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_res.valid) begin
            r_data <= i_res.data;
            r_kind <= i_res.kind;
            r_last <= i_res.last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_kind  = r_kind;
    assign o_last  = r_last;

endmodule

`default_nettype wire

### hw/rtl/length_checked_frame_deframer_unit.sv
// Byte-stream deframer: hunts for a two-byte sync pair, checks a little-endian
// length word against its negation, then passes the payload bytes with tlast
// on the final one. Failed checks, over-limit and zero lengths give one result
// each; on the first two the four header bytes are rescanned in the same cycle.
// One byte is accepted every clock cycle; a result leaves through a single
// output register in the cycle after its byte, and input stalls only while that
// register is full and the downstream side holds tready low. The header
// check and the four-byte rescan are combinational logic. The user must write
// configuration only while no request is in flight; not enforced by the block.
// depends on lcfd_pkg, lcfd_core, lcfd_outreg
`default_nettype none

module length_checked_frame_deframer_unit
    import lcfd_pkg::*;
#(
    parameter int LEN_WIDTH = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,  // [7:0] in_byte
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [7:0]                 m_axis_tdata,  // [7:0] out_byte
    output logic [1:0]                 m_axis_tuser,  // [1:0] out_kind
    output logic                       m_axis_tlast,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic    accept;
    logic    free;
    t_result res;
    t_kind   kind;

    // request accepted when the output slot can take its result
    assign s_axis_tready = free;
    assign accept        = s_axis_tvalid && free;

    lcfd_core #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_data     (s_axis_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_res      (res)
    );

    lcfd_outreg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .i_ready (m_axis_tready),
        .o_free  (free),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata),
        .o_kind  (kind),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tuser = kind;

endmodule

`default_nettype wire

### hw/rtl/lcfd_checker.sv
// lcfd_checker: port-level assertions for the deframer top level
// depends on lcfd_pkg; bound to length_checked_frame_deframer_unit
`default_nettype none

module lcfd_checker
    import lcfd_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic [1:0] m_axis_tuser,
    input wire logic       m_axis_tlast
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // full and stalled output blocks the input side
    a_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input ready while output slot blocked");

    // frame end mark only on payload bytes
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_PAYLOAD)
        else $error("tlast on a status result");

    // status results carry zero data
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_PAYLOAD |-> m_axis_tdata == 8'd0)
        else $error("status result with nonzero data");

endmodule

bind length_checked_frame_deframer_unit lcfd_checker u_lcfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

### bench/tb.sv
// tb: self-checking bench for length_checked_frame_deframer_unit, directed rows then
// random frames under several sync / length-limit settings, checked by a local predictor
// depends on lcfd_pkg and the deframer top level
`timescale 1ns / 1ps

module tb;
    import lcfd_pkg::*;

    localparam int LEN_W = 16;
    localparam logic [15:0] LEN_MASK = (LEN_W >= 16) ? 16'hFFFF : 16'((1 << LEN_W) - 1);
    localparam int ITEMS_PER_PHASE = 175;
    localparam int DRAIN_CYCLES = 6;
    localparam int STUCK_LIMIT = 1000;
    localparam int REPORT_LIMIT = 10;
    // index past the last register, must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // one deframer output as the predictor sees it
    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
        logic       last;
    } t_frame_out;

    // one directed stream byte, with an optional hand-typed result
    typedef struct {
        logic [7:0] b;
        bit         typed;
        t_frame_out want;
    } t_dir_row;

    localparam t_frame_out NO_RESULT = '{8'h00, KIND_PAYLOAD, 1'b0};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = 8'h00;  // [7:0] in_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;          // [7:0] out_byte
    logic [1:0]            m_axis_tuser;          // [1:0] out_kind
    logic                  m_axis_tlast;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    length_checked_frame_deframer_unit #(
        .LEN_WIDTH(LEN_W)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    // clock, 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor copy of the configuration
    logic [7:0]  cfg_first = SYNC_FIRST_RST;
    logic [7:0]  cfg_second = SYNC_SECOND_RST;
    logic [15:0] cfg_max = MAX_PAYLOAD_RST;

    // predictor copy of the hunter state
    t_phase      hunt_state = PH_HUNT;
    logic [15:0] hdr_len = '0;
    logic [15:0] hdr_chk = '0;
    logic [15:0] pay_left = '0;
    logic [7:0]  hdr_hold [4] = '{8'h00, 8'h00, 8'h00, 8'h00};
    logic [2:0]  hdr_count = '0;

    t_frame_out deframed_q[$];

    int mismatches = 0;
    int results_checked = 0;
    int bytes_sent = 0;
    int noise_bytes = 0;
    int settings_run = 1;
    int kind_seen [4] = '{0, 0, 0, 0};
    int burst_left = 0;
    int stuck_cycles = 0;

    // receiver stall pattern state
    int          stall_mode = 0;
    int          stall_tick = 0;
    logic [15:0] stall_mask = '0;

    // directed stream: repeated first sync, payload extremes, failed check
    // with a partial header in its four bytes, then an over-limit length
    t_dir_row dir_rows [23] = '{
        '{8'hA3, 1'b0, NO_RESULT},
        '{8'hA3, 1'b0, NO_RESULT},
        '{8'h97, 1'b0, NO_RESULT},
        '{8'h02, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'hFE, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, '{8'h00, KIND_PAYLOAD, 1'b0}},
        '{8'hFF, 1'b1, '{8'hFF, KIND_PAYLOAD, 1'b1}},
        '{8'hA3, 1'b0, NO_RESULT},
        '{8'h97, 1'b0, NO_RESULT},
        '{8'hA3, 1'b0, NO_RESULT},
        '{8'h97, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, '{8'h00, KIND_BAD_CHECK, 1'b0}},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'hA3, 1'b0, NO_RESULT},
        '{8'h97, 1'b0, NO_RESULT},
        '{8'h2A, 1'b0, NO_RESULT},
        '{8'h01, 1'b0, NO_RESULT},
        '{8'hD6, 1'b0, NO_RESULT},
        '{8'hFE, 1'b1, '{8'h00, KIND_TOO_LONG, 1'b0}}
    };

    // feed one byte to the header hunter, true when the fourth header byte lands
    function automatic bit hunt_step(input logic [7:0] b);
        case (hunt_state)
            PH_SAW_FIRST: begin
                if (b == cfg_second) begin
                    hunt_state = PH_HEADER;
                    hdr_count = '0;
                end else if (b != cfg_first) begin
                    hunt_state = PH_HUNT;
                end
                return 1'b0;
            end
            PH_HEADER: begin
                hdr_hold[hdr_count[1:0]] = b;
                case (hdr_count[1:0])
                    2'd0: hdr_len[7:0] = b;
                    2'd1: hdr_len[15:8] = b;
                    2'd2: hdr_chk[7:0] = b;
                    default: hdr_chk[15:8] = b;
                endcase
                hdr_count = hdr_count + 3'd1;
                return hdr_count >= 3'd4;
            end
            // hunting, and any unknown code
            default: begin
                hunt_state = (b == cfg_first) ? PH_SAW_FIRST : PH_HUNT;
                return 1'b0;
            end
        endcase
    endfunction

    // drop the sync pair and run the four header bytes through the hunter again
    function automatic void replay_header();
        logic [7:0] held [4];
        for (int k = 0; k < 4; k++) held[k] = hdr_hold[k];
        hunt_state = PH_HUNT;
        hdr_count = '0;
        for (int k = 0; k < 4; k++) void'(hunt_step(held[k]));
    endfunction

    // expected deframer output for one accepted stream byte
    function automatic void deframe_byte(input logic [7:0] b, output bit has,
                                         output t_frame_out r);
        logic [15:0] len;
        logic [15:0] chk;
        r = NO_RESULT;
        has = 1'b0;
        if (hunt_state == PH_PAYLOAD) begin
            r.last = (pay_left <= 16'd1);
            pay_left = r.last ? 16'd0 : pay_left - 16'd1;
            if (r.last) hunt_state = PH_HUNT;
            r.data = b;
            has = 1'b1;
            return;
        end
        if (!hunt_step(b)) return;
        len = hdr_len & LEN_MASK;
        chk = hdr_chk & LEN_MASK;
        has = 1'b1;
        if (((len + chk) & LEN_MASK) != 16'd0) begin
            r.kind = KIND_BAD_CHECK;
            replay_header();
        end else if (len > cfg_max) begin
            r.kind = KIND_TOO_LONG;
            replay_header();
        end else if (len == 16'd0) begin
            r.kind = KIND_EMPTY;
            hunt_state = PH_HUNT;
            hdr_count = '0;
        end else begin
            hunt_state = PH_PAYLOAD;
            pay_left = len;
            hdr_count = '0;
            has = 1'b0;
        end
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // send one byte in bursts with random gaps, then record what it should produce
    task automatic push_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input t_frame_out want = NO_RESULT);
        int gap;
        bit has;
        t_frame_out r;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
        deframe_byte(b, has, r);
        if (typed) deframed_q.push_back(want);
        else if (has) deframed_q.push_back(r);
    endtask

    // hold off the sender until every expected result is out, then let the pipe settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (deframed_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_SYNC_FIRST:  cfg_first = val[7:0];
            REG_SYNC_SECOND: cfg_second = val[7:0];
            REG_MAX_PAYLOAD: cfg_max = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_header(input logic [15:0] len, input logic [15:0] chk);
        push_byte(cfg_first);
        push_byte(cfg_second);
        push_byte(len[7:0]);
        push_byte(len[15:8]);
        push_byte(chk[7:0]);
        push_byte(chk[15:8]);
    endtask

    // mostly well-formed frames with random content, some broken ones and noise
    task automatic send_random_frame();
        int pick;
        int n;
        int cap;
        logic [15:0] len;
        logic [15:0] chk;
        pick = $urandom_range(0, 99);
        cap = (cfg_max > 16'd300) ? 300 : int'(cfg_max);
        if (pick >= 72 && pick < 82 && cfg_max == 16'hFFFF) pick = 65;
        if (pick < 60) begin
            // good frame, mostly short payloads
            n = $urandom_range(0, 19);
            if (n == 0 || cap == 0) len = 16'd0;
            else if (n == 1) len = 16'(cap);
            else if (n == 2) len = 16'($urandom_range(0, cap));
            else len = 16'($urandom_range(1, (cap < 12) ? cap : 12));
            send_header(len, ~len + 16'd1);
            for (int k = 0; k < int'(len); k++) push_byte(8'($urandom));
        end else if (pick < 72) begin
            // check word that cannot match
            len = 16'($urandom);
            chk = (~len + 16'd1) ^ 16'($urandom_range(1, 65535));
            send_header(len, chk);
        end else if (pick < 82) begin
            // valid check, length just or far over the limit
            if ($urandom_range(0, 2) == 0) len = cfg_max + 16'd1;
            else len = 16'($urandom_range(int'(cfg_max) + 1, 65535));
            send_header(len, ~len + 16'd1);
        end else if (pick < 90) begin
            // header cut short, the next bytes complete it
            push_byte(cfg_first);
            push_byte(cfg_second);
            n = $urandom_range(0, 3);
            for (int k = 0; k < n; k++) push_byte(8'($urandom));
        end else begin
            // line noise with stray first sync bytes
            n = $urandom_range(1, 8);
            for (int k = 0; k < n; k++)
                push_byte(($urandom_range(0, 3) == 0) ? cfg_first : 8'($urandom));
            noise_bytes += n;
        end
    endtask

    task automatic run_random_phase();
        int target;
        target = bytes_sent - noise_bytes + ITEMS_PER_PHASE;
        while (bytes_sent - noise_bytes < target) send_random_frame();
    endtask

    // receiver: always ready, random stalls, or a repeating mask, chosen anew when stall_tick runs out
    always @(posedge i_clk) begin
        if (stall_tick == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_mask <= 16'($urandom);
            stall_tick <= 48;
        end else begin
            stall_tick <= stall_tick - 1;
        end
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 9) < 7);
            default: m_axis_tready <= stall_mask[stall_tick[3:0]];
        endcase
    end

    // compare every accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_frame_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (deframed_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected result data=%02h kind=%0d last=%0b",
                                        m_axis_tdata, m_axis_tuser, m_axis_tlast));
            end else begin
                want = deframed_q.pop_front();
                results_checked++;
                kind_seen[want.kind]++;
                if (m_axis_tdata !== want.data)
                    flag_mismatch($sformatf("out_byte expected %02h got %02h",
                                            want.data, m_axis_tdata));
                if (m_axis_tuser !== want.kind)
                    flag_mismatch($sformatf("out_kind expected %0d got %0d",
                                            want.kind, m_axis_tuser));
                if (m_axis_tlast !== want.last)
                    flag_mismatch($sformatf("out_last expected %0b got %0b",
                                            want.last, m_axis_tlast));
            end
        end
    end

    // watchdog on cycles with no request moving on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("timeout: no traffic for %0d cycles, %0d results pending",
                     stuck_cycles, deframed_q.size());
            $display("Mismatches found");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // main sequence
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows under the reset settings
        foreach (dir_rows[i]) push_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);
        run_random_phase();

        // extremes: zero first sync, all-ones second sync, only empty frames fit
        wait_idle();
        set_reg(REG_SYNC_FIRST, 16'h0000);
        set_reg(REG_SYNC_SECOND, 16'h00FF);
        set_reg(REG_MAX_PAYLOAD, 16'h0000);
        settings_run++;
        run_random_phase();

        // equal sync bytes, no length limit, write to the spare index ignored
        wait_idle();
        set_reg(REG_SYNC_FIRST, 16'h00FF);
        set_reg(REG_MAX_PAYLOAD, 16'hFFFF);
        set_reg(REG_SPARE, 16'hFFFF);
        settings_run++;
        run_random_phase();

        // random sync pair, tight limit
        wait_idle();
        set_reg(REG_SYNC_FIRST, 16'($urandom_range(0, 255)));
        set_reg(REG_SYNC_SECOND, ($urandom_range(0, 3) == 0) ? {8'h00, cfg_first}
                                                               : 16'($urandom_range(0, 255)));
        set_reg(REG_MAX_PAYLOAD, 16'($urandom_range(1, 40)));
        settings_run++;
        run_random_phase();

        // back to the reset values
        wait_idle();
        set_reg(REG_SYNC_FIRST, {8'h00, SYNC_FIRST_RST});
        set_reg(REG_SYNC_SECOND, {8'h00, SYNC_SECOND_RST});
        set_reg(REG_MAX_PAYLOAD, MAX_PAYLOAD_RST);
        settings_run++;
        run_random_phase();

        wait_idle();
        $display("covered %0d stream bytes (%0d of them noise) over %0d register settings",
                 bytes_sent, noise_bytes, settings_run);
        $display("checked %0d results: %0d payload, %0d empty, %0d bad check, %0d over limit",
                 results_checked, kind_seen[KIND_PAYLOAD], kind_seen[KIND_EMPTY],
                 kind_seen[KIND_BAD_CHECK], kind_seen[KIND_TOO_LONG]);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/lcfd_pkg.sv
hw/rtl/lcfd_core.sv
hw/rtl/lcfd_outreg.sv
hw/rtl/length_checked_frame_deframer_unit.sv
hw/rtl/lcfd_checker.sv
bench/tb.sv
